// ===== design/bus_pkg.sv =====
// Package with the register indexes, operation codes, channel width and pixel type of the upscaler.
package bus_pkg;

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  typedef enum logic [7:0] {
    REG_WIDTH  = 8'd0,
    REG_HEIGHT = 8'd1
  } reg_idx_e;

  localparam int unsigned ChanBits = 8;

  typedef logic [ChanBits-1:0] chan_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } pixel_t;

endpackage

// ===== design/bus_lerp.sv =====
// Registered two-point interpolation of three colour channels with truncation toward zero.
module bus_lerp
  import bus_pkg::*;
#(
  parameter int unsigned SCALE = 8
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  pixel_t                   a_i,
  input  pixel_t                   b_i,
  input  logic [$clog2(SCALE)-1:0] f_i,
  output pixel_t                   y_o
);

  localparam int unsigned FW = $clog2(SCALE);
  localparam int unsigned PW = ChanBits + FW + 2;

  function automatic chan_t lerp_ch(chan_t a, chan_t b, logic [FW-1:0] f);
    logic signed [ChanBits+1:0] d;
    logic signed [PW-1:0]       p;
    logic        [PW-1:0]       m;
    logic        [PW-1:0]       q;
    logic signed [PW-1:0]       s;
    d = $signed({2'b00, b}) - $signed({2'b00, a});
    p = $signed({{(PW-FW){1'b0}}, f}) * PW'(d);
    m = p[PW-1] ? PW'(-p) : PW'(p);
    q = PW'(m / SCALE);
    s = p[PW-1] ? -$signed(q) : $signed(q);
    lerp_ch = chan_t'(PW'($signed({{(PW-ChanBits){1'b0}}, a}) + s));
  endfunction

  pixel_t y_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_q.red   <= lerp_ch(a_i.red,   b_i.red,   f_i);
      y_q.green <= lerp_ch(a_i.green, b_i.green, f_i);
      y_q.blue  <= lerp_ch(a_i.blue,  b_i.blue,  f_i);
    end
  end

  assign y_o = y_q;

endmodule

// ===== design/bilinear_upscale_by_integer_factor_top.sv =====
// Top level of the bilinear upscaler by an integer factor.
// The block stores a source image in one single-port memory of MAX_WIDTH*MAX_HEIGHT pixels.
// A write transaction uses the memory port once. A read transaction holds the port
// for four fetches, one for each neighbouring source pixel, and the input is ready again only
// in the cycle after the last fetch, so no new transaction is taken while a read's fetches
// are under way; writes are accepted at one per cycle while no fetch or stall holds the input.
// The four fetches are followed by a vertical stage (two interpolations in parallel), a
// horizontal stage and an output register. There is no clearing pass.
module bilinear_upscale_by_integer_factor_top
  import bus_pkg::*;
#(
  parameter int unsigned SCALE      = 8,
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata from bit 0: src_row[8], src_col[8], out_row[11], out_col[11],
  // in_red[8], in_green[8], in_blue[8], zero padding.
  input  logic [63:0] s_axis_tdata,
  input  logic        s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata from bit 0: out_red[8], out_green[8], out_blue[8].
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tuser,   // inside_res
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [8:0]  cfg_data_i
);

  localparam int unsigned FW  = $clog2(SCALE);
  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT);
  localparam int unsigned AW  = CW + RW;
  localparam int unsigned DW  = 13;
  localparam int unsigned OW  = 11;

  logic [DW-1:0] width_q, height_q;
  logic [DW-1:0] w_eff, h_eff;
  logic [DW+FW:0] ow_lim, oh_lim;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DW'(256);
      height_q <= DW'(256);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_WIDTH:  width_q  <= DW'(cfg_data_i);
        REG_HEIGHT: height_q <= DW'(cfg_data_i);
        default: ;
      endcase
    end
  end

  assign w_eff = (width_q == '0) ? DW'(1) :
                 (width_q > DW'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : width_q;
  assign h_eff = (height_q == '0) ? DW'(1) :
                 (height_q > DW'(MAX_HEIGHT)) ? DW'(MAX_HEIGHT) : height_q;
  assign ow_lim = (DW+FW+1)'(w_eff - DW'(1)) * (DW+FW+1)'(SCALE) + (DW+FW+1)'(1);
  assign oh_lim = (DW+FW+1)'(h_eff - DW'(1)) * (DW+FW+1)'(SCALE) + (DW+FW+1)'(1);

  // Input fields.
  logic [7:0]    in_srow, in_scol;
  logic [OW-1:0] in_orow, in_ocol;
  pixel_t        in_px;
  assign in_srow     = s_axis_tdata[7:0];
  assign in_scol     = s_axis_tdata[15:8];
  assign in_orow     = s_axis_tdata[26:16];
  assign in_ocol     = s_axis_tdata[37:27];
  assign in_px.red   = s_axis_tdata[45:38];
  assign in_px.green = s_axis_tdata[53:46];
  assign in_px.blue  = s_axis_tdata[61:54];

  // Fetch sequencer: holds one read for its four fetches.
  logic          busy_q;
  logic [1:0]    ph_q;
  logic [RW-1:0] r0_q, r1_q;
  logic [CW-1:0] c0_q, c1_q;
  logic [FW-1:0] fy_q, fx_q;
  logic          ins_q;
  logic          stall;
  logic          accept;

  logic [OW-1:0] rq, cq;
  logic [FW-1:0] fy, fx;
  logic          ins;
  assign rq  = OW'(in_orow / SCALE);
  assign cq  = OW'(in_ocol / SCALE);
  assign fy  = FW'(in_orow % SCALE);
  assign fx  = FW'(in_ocol % SCALE);
  assign ins = ((DW+FW+1)'(in_orow) < oh_lim) && ((DW+FW+1)'(in_ocol) < ow_lim);

  assign s_axis_tready = !busy_q && !stall;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ph_q   <= '0;
    end else if (!stall) begin
      if (accept && s_axis_tuser == OP_READ) begin
        busy_q <= 1'b1;
        ph_q   <= 2'd0;
      end else if (busy_q) begin
        ph_q   <= ph_q + 2'd1;
        busy_q <= (ph_q != 2'd3);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && s_axis_tuser == OP_READ) begin
      r0_q  <= RW'(rq);
      c0_q  <= CW'(cq);
      r1_q  <= (fy != '0) ? RW'(rq + OW'(1)) : RW'(rq);
      c1_q  <= (fx != '0) ? CW'(cq + OW'(1)) : CW'(cq);
      fy_q  <= fy;
      fx_q  <= fx;
      ins_q <= ins;
    end
  end

  // Memory: single port, registered read.
  logic [23:0]   mem [2**AW];
  logic          wr_en;
  logic [AW-1:0] rd_addr;
  logic [23:0]   rd_q;
  logic          rd_v_q;
  logic [1:0]    rd_ph_q;

  assign wr_en = accept && s_axis_tuser == OP_WRITE &&
                 (DW'(in_srow) < h_eff) && (DW'(in_scol) < w_eff);

  always_comb begin
    case (ph_q)
      2'd0:    rd_addr = {r0_q, c0_q};
      2'd1:    rd_addr = {r1_q, c0_q};
      2'd2:    rd_addr = {r0_q, c1_q};
      default: rd_addr = {r1_q, c1_q};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[{RW'(in_srow), CW'(in_scol)}] <= in_px;
    end else if (busy_q && !stall) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q  <= 1'b0;
      rd_ph_q <= '0;
    end else if (!stall) begin
      rd_v_q  <= busy_q;
      rd_ph_q <= ph_q;
    end
  end

  // Gather the four pixels.
  pixel_t        p00_q, p10_q, p01_q;
  logic          g_v_q;
  pixel_t        g00_q, g10_q, g01_q, g11_q;
  logic [FW-1:0] g_fy_q, g_fx_q;
  logic          g_ins_q;

  always_ff @(posedge clk_i) begin
    if (rd_v_q && !stall) begin
      case (rd_ph_q)
        2'd0: p00_q <= rd_q;
        2'd1: p10_q <= rd_q;
        2'd2: p01_q <= rd_q;
        default: begin
          g00_q   <= p00_q;
          g10_q   <= p10_q;
          g01_q   <= p01_q;
          g11_q   <= rd_q;
          g_fy_q  <= fy_q;
          g_fx_q  <= fx_q;
          g_ins_q <= ins_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_v_q <= 1'b0;
    end else if (!stall) begin
      g_v_q <= rd_v_q && rd_ph_q == 2'd3;
    end
  end

  // Vertical stage.
  pixel_t        left, right;
  logic          v_v_q;
  logic [FW-1:0] v_fx_q;
  logic          v_ins_q;

  bus_lerp #(.SCALE(SCALE)) u_left (
    .clk_i, .en_i(!stall), .a_i(g00_q), .b_i(g10_q), .f_i(g_fy_q), .y_o(left)
  );
  bus_lerp #(.SCALE(SCALE)) u_right (
    .clk_i, .en_i(!stall), .a_i(g01_q), .b_i(g11_q), .f_i(g_fy_q), .y_o(right)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_v_q <= 1'b0;
    end else if (!stall) begin
      v_v_q <= g_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall) begin
      v_fx_q  <= g_fx_q;
      v_ins_q <= g_ins_q;
    end
  end

  // Horizontal stage.
  pixel_t hz;
  logic   h_v_q;
  logic   h_ins_q;

  bus_lerp #(.SCALE(SCALE)) u_horiz (
    .clk_i, .en_i(!stall), .a_i(left), .b_i(right), .f_i(v_fx_q), .y_o(hz)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_v_q <= 1'b0;
    end else if (!stall) begin
      h_v_q <= v_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall) begin
      h_ins_q <= v_ins_q;
    end
  end

  // Output register.
  logic   o_v_q;
  pixel_t o_px_q;
  logic   o_ins_q;

  assign stall = o_v_q && !m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
    end else if (!stall) begin
      o_v_q <= h_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall && h_v_q) begin
      o_px_q  <= h_ins_q ? hz : '0;
      o_ins_q <= h_ins_q;
    end
  end

  assign m_axis_tvalid = o_v_q;
  assign m_axis_tdata  = {o_px_q.blue, o_px_q.green, o_px_q.red};
  assign m_axis_tuser  = o_ins_q;

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |=> o_v_q && $stable(m_axis_tdata))
    else $error("Output changed during a stall.");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !accept)
    else $error("Transaction accepted during a fetch.");
  a_phase_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && ph_q == 2'd3 && !stall) |=> !busy_q)
    else $error("Fetch sequence overran.");

endmodule
